// ===== sv/assert_macros.svh =====
// Assertion macros shared by the timer queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock and held off during reset.
`define CHECK_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and held off during reset.
`define CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/mhtq_pkg.sv =====
// Types, codes and helpers shared by the timer queue modules.
package mhtq_pkg;

   localparam int POS_W    = 6;
   localparam int CNT_W    = 6;
   localparam int TIME_W   = 32;
   localparam int ID_W     = 8;
   localparam int TMO_W    = 24;
   localparam int ELP_W    = 16;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;
   localparam int OP_W     = 2;

   localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADJUST = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TICK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

   localparam logic [OP_W-1:0] OP_HOLD  = 2'd0;
   localparam logic [OP_W-1:0] OP_SWAP  = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

   localparam logic [TMO_W-1:0] WAIT_MAX = 24'hFFFFFF;

   typedef struct packed {
      logic [TIME_W-1:0] expiry;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] upper_idx;
      logic [POS_W-1:0] lower_idx;
      logic             lower_right;
      logic [POS_W-1:0] wr_idx;
      logic             wr_id_en;
      entry_type        wr_entry;
   } cell_cmd_type;

   typedef struct packed {
      logic lt_left;
      logic lt_right;
      logic right_lt_left;
   } cell_flags_type;

   // Wrapping time order: a is earlier than b when a - b is negative.
   function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return diff[TIME_W-1];
   endfunction

endpackage

// ===== sv/mhtq_cell.sv =====
// One heap slot: holds an entry, swaps with its tree neighbors and compares against its children.
module mhtq_cell
   import mhtq_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic           clock,
   input  cell_cmd_type   cmd,
   input  entry_type      parent_entry,
   input  entry_type      left_entry,
   input  entry_type      right_entry,
   output entry_type      entry,
   output cell_flags_type flags
);

   localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         OP_SWAP: begin
            // The upper slot pulls from the chosen child, the lower slot from its parent.
            if (cmd.upper_idx == MY_IDX) begin
               entry_in = cmd.lower_right ? right_entry : left_entry;
            end else if (cmd.lower_idx == MY_IDX) begin
               entry_in = parent_entry;
            end
         end
         OP_WRITE: begin
            if (cmd.wr_idx == MY_IDX) begin
               entry_in.expiry = cmd.wr_entry.expiry;
               if (cmd.wr_id_en) begin
                  entry_in.id = cmd.wr_entry.id;
               end
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry               = entry_ff;
   assign flags.lt_left       = earlier(entry_ff.expiry, left_entry.expiry);
   assign flags.lt_right      = earlier(entry_ff.expiry, right_entry.expiry);
   assign flags.right_lt_left = earlier(right_entry.expiry, left_entry.expiry);

endmodule

// ===== sv/min_heap_timer_queue.sv =====
// Timer queue: a binary min-heap of armed timers kept in a row of cells, one cell per heap
// slot, each wired to its parent and children, plus a 32-bit millisecond time counter. Timers
// are found by id through a compare on every live cell. An item is decoded, its entry is then
// swapped one heap level at a time in sift passes, and a summary word is put out; a tick also
// puts out, for each expired timer, a fired word and re-sifts the refilled root. The
// compare-and-swap sequencer walks one heap level per cycle. A new item is taken once the
// summary word has been written to the output register, even while that word still waits
// to be taken.
`include "assert_macros.svh"

module min_heap_timer_queue
   import mhtq_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // timer_id[7:0], timeout_ms[31:8], elapsed_ms[47:32]
   input  logic [2:0]  req_tuser,   // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // fired_id[7:0], status[9:8], has_pending[10],
                                    // next_wait_ms[34:11], zero fill[39:35]
   output logic [0:0]  rsp_tuser,   // fired[0]
   output logic        rsp_tlast
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_LOOKUP  = 3'd1;
   localparam logic [2:0] S_DOWN    = 3'd2;
   localparam logic [2:0] S_UP      = 3'd3;
   localparam logic [2:0] S_TICK    = 3'd4;
   localparam logic [2:0] S_SUMMARY = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [TMO_W-1:0]    tmo_ff, tmo_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [POS_W-1:0]    cursor_ff, cursor_in;
   logic                moved_ff, moved_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                sum_fired_ff, sum_fired_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_fired_ff, rsp_fired_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_pend_ff, rsp_pend_in;
   logic [TMO_W-1:0]    rsp_wait_ff, rsp_wait_in;
   logic                rsp_last_ff, rsp_last_in;

   entry_type      cell_entry [CAPACITY];
   cell_flags_type cell_flags [CAPACITY];
   cell_cmd_type   cell_cmd;

   logic                req_accept;
   logic                out_free;
   logic                present;
   logic [POS_W-1:0]    pos;
   logic [POS_W-1:0]    tail_idx;
   logic [POS_W-1:0]    parent_idx;
   logic [POS_W:0]      left_idx;
   logic [POS_W:0]      right_idx;
   entry_type           tail_entry;
   cell_flags_type      cur_flags;
   cell_flags_type      par_flags;
   logic [TIME_W-1:0]   root_diff;
   logic                root_expired;
   logic [TMO_W-1:0]    root_wait;
   logic [TIME_W-1:0]   new_expiry;
   logic [2:0]          ret_state;
   logic                pick_right;
   logic                self_lt;
   logic                parent_lt;

   // Heap slots: each cell sees its own parent and children through fixed wiring.
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      localparam int PAR = (k == 0) ? 0 : (k - 1) / 2;
      localparam int LFT = (2 * k + 1 < CAPACITY) ? 2 * k + 1 : k;
      localparam int RGT = (2 * k + 2 < CAPACITY) ? 2 * k + 2 : k;

      mhtq_cell #(
         .INDEX (k)
      ) u_cell (
         .clock        (clock),
         .cmd          (cell_cmd),
         .parent_entry (cell_entry[PAR]),
         .left_entry   (cell_entry[LFT]),
         .right_entry  (cell_entry[RGT]),
         .entry        (cell_entry[k]),
         .flags        (cell_flags[k])
      );
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign tail_idx   = count_ff - POS_W'(1);
   assign parent_idx = (cursor_ff - POS_W'(1)) >> 1;
   assign left_idx   = {cursor_ff, 1'b0} + (POS_W + 1)'(1);
   assign right_idx  = {cursor_ff, 1'b0} + (POS_W + 1)'(2);
   assign new_expiry = time_ff + TIME_W'(tmo_ff);
   assign ret_state  = (kind_ff == KIND_TICK) ? S_TICK : S_SUMMARY;

   // Root timing: expired when its expiry is at or before now.
   assign root_diff    = cell_entry[0].expiry - time_ff;
   assign root_expired = (root_diff == '0) || root_diff[TIME_W-1];
   assign root_wait    = root_diff[TIME_W-1] ? '0 :
                         (|root_diff[TIME_W-1:TMO_W]) ? WAIT_MAX : root_diff[TMO_W-1:0];

   // Id search over the live cells, plus selection of the tail entry and the cursor and parent flags.
   always_comb begin
      present    = 1'b0;
      pos        = '0;
      tail_entry = '0;
      cur_flags  = '0;
      par_flags  = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         if ((POS_W'(k) < count_ff) && (cell_entry[k].id == id_ff)) begin
            present = 1'b1;
            pos     = POS_W'(k);
         end
         if (tail_idx == POS_W'(k)) begin
            tail_entry = cell_entry[k];
         end
         if (cursor_ff == POS_W'(k)) begin
            cur_flags = cell_flags[k];
         end
         if (parent_idx == POS_W'(k)) begin
            par_flags = cell_flags[k];
         end
      end
   end

   assign pick_right = (right_idx < {1'b0, count_ff}) && cur_flags.right_lt_left;
   assign self_lt    = pick_right ? cur_flags.lt_right : cur_flags.lt_left;
   // An odd cursor is the left child of its parent.
   assign parent_lt  = cursor_ff[0] ? par_flags.lt_left : par_flags.lt_right;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      tmo_in        = tmo_ff;
      time_in       = time_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      moved_in      = moved_ff;
      status_in     = status_ff;
      sum_fired_in  = sum_fired_ff;
      cell_cmd      = '0;
      cell_cmd.op   = OP_HOLD;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_fired_in  = rsp_fired_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pend_in   = rsp_pend_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               kind_in  = req_tuser;
               id_in    = req_tdata[7:0];
               tmo_in   = req_tdata[31:8];
               state_in = S_LOOKUP;
               if (req_tuser == KIND_TICK) begin
                  time_in = time_ff + TIME_W'(req_tdata[47:32]);
               end
            end
         end

         S_LOOKUP: begin
            status_in    = ST_OK;
            sum_fired_in = 1'b0;
            moved_in     = 1'b0;
            state_in     = S_SUMMARY;
            case (kind_ff)
               KIND_ADD, KIND_ADJUST: begin
                  if (present) begin
                     cell_cmd.op              = OP_WRITE;
                     cell_cmd.wr_idx          = pos;
                     cell_cmd.wr_id_en        = 1'b0;
                     cell_cmd.wr_entry.expiry = new_expiry;
                     cursor_in                = pos;
                     state_in                 = S_DOWN;
                  end else if (kind_ff == KIND_ADJUST) begin
                     status_in = ST_ABSENT;
                  end else if (count_ff >= CNT_W'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     cell_cmd.op              = OP_WRITE;
                     cell_cmd.wr_idx          = count_ff;
                     cell_cmd.wr_id_en        = 1'b1;
                     cell_cmd.wr_entry.expiry = new_expiry;
                     cell_cmd.wr_entry.id     = id_ff;
                     count_in                 = count_ff + CNT_W'(1);
                     cursor_in                = count_ff;
                     state_in                 = S_UP;
                  end
               end
               KIND_CANCEL: begin
                  if (present) begin
                     sum_fired_in = 1'b1;
                     count_in     = count_ff - CNT_W'(1);
                     // The tail entry fills the hole and is then re-sifted.
                     if (pos != tail_idx) begin
                        cell_cmd.op       = OP_WRITE;
                        cell_cmd.wr_idx   = pos;
                        cell_cmd.wr_id_en = 1'b1;
                        cell_cmd.wr_entry = tail_entry;
                        cursor_in         = pos;
                        state_in          = S_DOWN;
                     end
                  end else begin
                     status_in = ST_ABSENT;
                  end
               end
               KIND_TICK: begin
                  state_in = S_TICK;
               end
               KIND_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  state_in = S_SUMMARY;
               end
            endcase
         end

         S_DOWN: begin
            if ((left_idx >= {1'b0, count_ff}) || self_lt) begin
               // Sift-down is over; an entry that did not move gets a sift-up pass.
               state_in = moved_ff ? ret_state : S_UP;
            end else begin
               cell_cmd.op          = OP_SWAP;
               cell_cmd.upper_idx   = cursor_ff;
               cell_cmd.lower_idx   = pick_right ? right_idx[POS_W-1:0] : left_idx[POS_W-1:0];
               cell_cmd.lower_right = pick_right;
               cursor_in            = pick_right ? right_idx[POS_W-1:0] : left_idx[POS_W-1:0];
               moved_in             = 1'b1;
            end
         end

         S_UP: begin
            if ((cursor_ff == '0) || parent_lt) begin
               state_in = ret_state;
            end else begin
               cell_cmd.op          = OP_SWAP;
               cell_cmd.upper_idx   = parent_idx;
               cell_cmd.lower_idx   = cursor_ff;
               cell_cmd.lower_right = !cursor_ff[0];
               cursor_in            = parent_idx;
            end
         end

         S_TICK: begin
            if ((count_ff != '0) && root_expired) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_fired_in  = 1'b1;
                  rsp_id_in     = cell_entry[0].id;
                  rsp_status_in = ST_OK;
                  rsp_pend_in   = 1'b0;
                  rsp_wait_in   = '0;
                  rsp_last_in   = 1'b0;
                  count_in      = count_ff - CNT_W'(1);
                  moved_in      = 1'b0;
                  cursor_in     = '0;
                  if (tail_idx != '0) begin
                     cell_cmd.op       = OP_WRITE;
                     cell_cmd.wr_idx   = '0;
                     cell_cmd.wr_id_en = 1'b1;
                     cell_cmd.wr_entry = tail_entry;
                     state_in          = S_DOWN;
                  end
               end
            end else begin
               state_in = S_SUMMARY;
            end
         end

         S_SUMMARY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_fired_in  = sum_fired_ff;
               rsp_id_in     = sum_fired_ff ? id_ff : '0;
               rsp_status_in = status_ff;
               rsp_pend_in   = (count_ff != '0);
               rsp_wait_in   = (count_ff != '0) ? root_wait : '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         time_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      tmo_ff        <= tmo_in;
      cursor_ff     <= cursor_in;
      moved_ff      <= moved_in;
      status_ff     <= status_in;
      sum_fired_ff  <= sum_fired_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pend_ff   <= rsp_pend_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_wait_ff, rsp_pend_ff, rsp_status_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_fired_ff;
   assign rsp_tlast  = rsp_last_ff;

   `CHECK_IMPLIES(a_count_cap, 1'b1, count_ff <= CNT_W'(CAPACITY), "entry count above capacity")
   `CHECK_IMPLIES(a_cursor_live, (state_ff == S_DOWN) || (state_ff == S_UP),
                  cursor_ff < count_ff, "sift cursor outside the live heap")
   `CHECK_IMPLIES(a_fire_word, rsp_valid_ff && !rsp_last_ff, rsp_fired_ff && !rsp_pend_ff,
                  "non-final word is not a bare fired report")
   `CHECK_NEXT(a_summary_done, (state_ff == S_SUMMARY) && out_free, state_ff == S_IDLE,
               "summary word sent but sequencer not idle")

endmodule
